// ----- rtl/core/iss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_pkg
// Types, codes and helpers shared by the integer string scanner.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned RadixW  = 6;
  localparam int unsigned DigitW  = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ProdW   = ValueW + RadixW + 1;

  localparam logic [DigitW-1:0]  NotADigit = 8'hff;
  localparam logic [7:0]         CharMinus = 8'h2d;
  localparam logic [7:0]         CharUnder = 8'h5f;
  localparam logic [RadixW-1:0]  RadixMax  = 6'd36;
  localparam logic [RadixW-1:0]  RadixOne  = 6'd1;
  localparam logic [RadixW-1:0]  RadixZero = 6'd0;
  localparam logic [RadixW-1:0]  RadixRst  = 6'd10;
  localparam logic [ValueW-1:0]  ValueMax  = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusInvalid = 2'd1;
  localparam logic [StatusW-1:0] StatusRange   = 2'd2;

  localparam logic [1:0] RegRadix  = 2'd0;
  localparam logic [1:0] RegLimit  = 2'd1;
  localparam logic [1:0] RegNegate = 2'd2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [StatusW-1:0] status;
  } out_beat_t;

  typedef struct packed {
    logic [ValueW-1:0] acc;
    logic              overflowed;
    logic              negative;
    logic              at_first;
    logic              literal;
    logic              digit_seen;
    logic              bad;
  } scan_state_t;

  localparam scan_state_t StateClear = '{
    acc: '0, overflowed: 1'b0, negative: 1'b0, at_first: 1'b1,
    literal: 1'b0, digit_seen: 1'b0, bad: 1'b0
  };

  function automatic logic [DigitW-1:0] digit_of(input logic [7:0] c);
    logic [DigitW-1:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'h41 + 8'd10;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      d = c - 8'h61 + 8'd10;
    end else begin
      d = NotADigit;
    end
    return d;
  endfunction

endpackage

// ----- rtl/core/iss_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_step
// Per-byte state update: sign, underscore skip, digit check, multiply-add
// with exact overflow detection.
// ----------------------------------------------------------------------------
module iss_step
  import iss_pkg::*;
(
  input  scan_state_t       state_i,
  input  in_beat_t          beat_i,
  input  logic [RadixW-1:0] radix_i,
  output scan_state_t       state_o
);

  logic [DigitW-1:0] digit;
  logic [ProdW-1:0]  prod;
  logic              take;

  assign digit = digit_of(beat_i.char_byte);
  assign prod  = ProdW'(state_i.acc) * ProdW'(radix_i) + ProdW'(digit);

  always_comb begin
    state_o = state_i;
    take    = 1'b0;
    if (state_i.at_first) begin
      state_o.at_first = 1'b0;
      if (beat_i.char_byte == CharMinus) begin
        state_o.negative = 1'b1;
      end else begin
        take = 1'b1;
      end
    end else if (!state_i.literal && beat_i.char_byte == CharUnder && !beat_i.is_last) begin
      state_o.literal = 1'b1;
    end else begin
      state_o.literal = 1'b0;
      take = 1'b1;
    end

    if (take && !state_i.bad) begin
      if (digit >= DigitW'(radix_i) || radix_i == RadixZero) begin
        state_o.bad = 1'b1;
      end else begin
        state_o.digit_seen = 1'b1;
        if (!state_i.overflowed) begin
          if (prod[ProdW-1:ValueW] != '0) begin
            state_o.overflowed = 1'b1;
          end else begin
            state_o.acc = prod[ValueW-1:0];
          end
        end
      end
    end
  end

endmodule

// ----- rtl/core/iss_finish.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_finish
// End-of-string result: radix check, validity, sign and limit rules.
// ----------------------------------------------------------------------------
module iss_finish
  import iss_pkg::*;
(
  input  scan_state_t       state_i,
  input  logic [RadixW-1:0] radix_i,
  input  logic [ValueW-1:0] limit_i,
  input  logic              negate_i,
  output out_beat_t         result_o
);

  logic              neg;
  logic [ValueW-1:0] y;

  always_comb begin
    result_o.value  = '0;
    result_o.status = StatusOk;
    neg = state_i.negative | negate_i;
    y   = state_i.acc;
    if (radix_i == RadixOne || radix_i > RadixMax) begin
      result_o.status = StatusRange;
    end else if (state_i.bad || !state_i.digit_seen) begin
      result_o.status = StatusInvalid;
    end else begin
      if (state_i.overflowed) begin
        result_o.status = StatusRange;
        y = limit_i;
        if (limit_i[0]) begin
          neg = 1'b0;
        end
      end
      result_o.value = neg ? (ValueW'(0) - y) : y;
      if (y >= limit_i) begin
        if (!limit_i[0] && !neg) begin
          result_o.value  = limit_i - ValueW'(1);
          result_o.status = StatusRange;
        end else if (y > limit_i) begin
          result_o.value  = limit_i;
          result_o.status = StatusRange;
        end
      end
    end
  end

endmodule

// ----- rtl/core/integer_string_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_string_scanner
// Streams a string one byte per beat and returns its integer value.
//
// Input channel (in_valid_i/in_ready_o, in_data_i): one byte per beat, with
// is_last on the final byte. Output channel (out_valid_o/out_ready_i,
// out_data_o): one beat per string, value and status.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 radix, 1 upper limit,
// 2 negate-always; always ready, write only while the block is idle.
// Throughput: one byte per cycle unless a last byte waits on a stalled result,
// set by the single 64x6 multiply-add in the byte update. A last byte passes
// the input register, then its result is held in the result register.
// A stalled output holds its result; further bytes keep flowing until the
// next last byte reaches the head of the pipe, which then waits.
// Reset clears the string state and loads radix 10, limit all ones and
// negate-always 0; no result is pending.
// ----------------------------------------------------------------------------
module integer_string_scanner
  import iss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic              in_valid_q;
  in_beat_t          in_q;
  scan_state_t       state_q, state_d, state_upd;
  logic [RadixW-1:0] radix_q;
  logic [ValueW-1:0] limit_q;
  logic              negate_q;
  logic              out_valid_q;
  out_beat_t         out_q, result;
  logic              out_free, advance;

  iss_step u_step (
    .state_i (state_q),
    .beat_i  (in_q),
    .radix_i (radix_q),
    .state_o (state_upd)
  );

  iss_finish u_finish (
    .state_i  (state_upd),
    .radix_i  (radix_q),
    .limit_i  (limit_q),
    .negate_i (negate_q),
    .result_o (result)
  );

  assign out_free    = !out_valid_q || out_ready_i;
  assign advance     = in_valid_q && (!in_q.is_last || out_free);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign state_d     = in_q.is_last ? StateClear : state_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateClear;
      radix_q     <= RadixRst;
      limit_q     <= ValueMax;
      negate_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && in_q.is_last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegRadix:  radix_q  <= cfg_data_i[RadixW-1:0];
          RegLimit:  limit_q  <= cfg_data_i;
          RegNegate: negate_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance && in_q.is_last) begin
      out_q <= result;
    end
  end

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == StatusOk || out_data_o.status == StatusInvalid
                     || out_data_o.status == StatusRange))
    else $error("result status code out of range");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StatusInvalid |-> out_data_o.value == '0)
    else $error("invalid string must report zero");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.is_last |=> state_q.at_first && state_q.acc == '0 && !state_q.bad)
    else $error("string state not cleared after last byte");

  a_result_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_q.is_last && out_valid_q && !out_ready_i |=> in_valid_q && out_valid_q)
    else $error("last byte advanced over a stalled result");
`endif

endmodule

// ----- sim/integer_string_scanner_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_string_scanner_test
// Self-checking bench for the integer string scanner.
//
// A short table of hand-picked strings runs first, followed by random
// strings under a series of radix, limit and negate settings. These include
// bad radices, zero, even and odd limits, and values near overflow. Each
// accepted byte runs through a scanner model kept in the bench, and every
// result beat is compared with the oldest predicted result. In most phases
// the sender works in bursts with gaps and the receiver stalls on a random
// pattern. One phase holds the output off long enough to back the input up.
// ----------------------------------------------------------------------------
module integer_string_scanner_test;
  import iss_pkg::*;

  localparam int unsigned NumRows       = 23;
  localparam int unsigned NumPhases     = 14;
  localparam int unsigned PhaseBeats    = 130;
  localparam int unsigned HoldPhase     = 3;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct {
    logic [7:0] ch;
    bit         last;
    bit         typed;
    out_beat_t  known;
  } dir_row_t;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t known;
  } pending_beat_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_beat_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_beat_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = RegRadix;
  logic [63:0] cfg_data_i = '0;

  // settings as the scanner holds them
  logic [RadixW-1:0] cfg_radix = RadixRst;
  logic [ValueW-1:0] cfg_limit = ValueMax;
  logic              cfg_neg   = 1'b0;

  // string state of the scanner model
  logic [ValueW-1:0] acc_val       = '0;
  bit                acc_ovf       = 1'b0;
  bit                neg_seen      = 1'b0;
  bit                first_pending = 1'b1;
  bit                literal_next  = 1'b0;
  bit                any_digit     = 1'b0;
  bit                bad_seen      = 1'b0;

  pending_beat_t byte_queue[$];
  out_beat_t     expected_results[$];

  bit          in_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit          steady_send = 1'b1;
  bit          steady_recv = 1'b1;
  logic [15:0] recv_pattern = 16'hffff;
  logic [3:0]  pat_idx = '0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  int unsigned beats_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned results_checked = 0;
  int unsigned invalid_seen = 0;
  int unsigned range_seen = 0;
  int unsigned mismatches = 0;

  dir_row_t dir_rows [NumRows] = '{
    '{8'h30, 1'b1, 1'b1, '{64'd0, StatusOk}},
    '{CharMinus, 1'b1, 1'b1, '{64'd0, StatusInvalid}},
    '{8'hff, 1'b1, 1'b1, '{64'd0, StatusInvalid}},
    '{8'h00, 1'b1, 1'b1, '{64'd0, StatusInvalid}},
    '{CharUnder, 1'b1, 1'b1, '{64'd0, StatusInvalid}},
    '{CharMinus, 1'b0, 1'b0, '{64'd0, StatusOk}},
    '{8'h37, 1'b1, 1'b0, '{64'd0, StatusOk}},
    '{8'h39, 1'b0, 1'b0, '{64'd0, StatusOk}},
    '{CharUnder, 1'b0, 1'b0, '{64'd0, StatusOk}},
    '{8'h39, 1'b1, 1'b0, '{64'd0, StatusOk}},
    '{8'h31, 1'b0, 1'b0, '{64'd0, StatusOk}},
    '{CharUnder, 1'b0, 1'b0, '{64'd0, StatusOk}},
    '{CharUnder, 1'b0, 1'b0, '{64'd0, StatusOk}},
    '{8'h32, 1'b1, 1'b1, '{64'd0, StatusInvalid}},
    '{CharMinus, 1'b0, 1'b0, '{64'd0, StatusOk}},
    '{CharMinus, 1'b0, 1'b0, '{64'd0, StatusOk}},
    '{8'h31, 1'b1, 1'b1, '{64'd0, StatusInvalid}},
    '{8'h34, 1'b0, 1'b0, '{64'd0, StatusOk}},
    '{CharUnder, 1'b1, 1'b1, '{64'd0, StatusInvalid}},
    '{8'h41, 1'b0, 1'b0, '{64'd0, StatusOk}},
    '{8'h7a, 1'b0, 1'b0, '{64'd0, StatusOk}},
    '{8'hff, 1'b0, 1'b0, '{64'd0, StatusOk}},
    '{8'h33, 1'b1, 1'b1, '{64'd0, StatusInvalid}}
  };

  integer_string_scanner dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] char_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h41 && c <= 8'h5a) return c - 8'h41 + 8'd10;
    if (c >= 8'h61 && c <= 8'h7a) return c - 8'h61 + 8'd10;
    return NotADigit;
  endfunction

  function automatic void absorb_digit(input logic [7:0] c);
    logic [7:0] d;
    d = char_value(c);
    if (bad_seen) return;
    if (d >= {2'b00, cfg_radix} || cfg_radix == RadixZero) begin
      bad_seen = 1'b1;
      return;
    end
    any_digit = 1'b1;
    if (acc_ovf) return;
    if (acc_val > (ValueMax - d) / cfg_radix) begin
      acc_ovf = 1'b1;
    end else begin
      acc_val = acc_val * cfg_radix + d;
    end
  endfunction

  // Advance the string state by one byte; on the last byte give the result.
  function automatic bit scan_byte(input in_beat_t b, output out_beat_t res);
    logic [ValueW-1:0]  mag;
    logic [ValueW-1:0]  val;
    logic [StatusW-1:0] st;
    bit                 neg;
    res = '0;
    if (first_pending) begin
      first_pending = 1'b0;
      if (b.char_byte == CharMinus) neg_seen = 1'b1;
      else absorb_digit(b.char_byte);
    end else if (!literal_next && b.char_byte == CharUnder && !b.is_last) begin
      literal_next = 1'b1;
    end else begin
      literal_next = 1'b0;
      absorb_digit(b.char_byte);
    end
    if (!b.is_last) return 1'b0;

    neg = neg_seen || cfg_neg;
    val = '0;
    st  = StatusOk;
    if (cfg_radix == RadixOne || cfg_radix > RadixMax) begin
      st = StatusRange;
    end else if (bad_seen || !any_digit) begin
      st = StatusInvalid;
    end else begin
      mag = acc_val;
      if (acc_ovf) begin
        st  = StatusRange;
        mag = cfg_limit;
        if (cfg_limit[0]) neg = 1'b0;
      end
      val = neg ? (64'd0 - mag) : mag;
      if (mag >= cfg_limit) begin
        if (!cfg_limit[0] && !neg) begin
          val = cfg_limit - 64'd1;
          st  = StatusRange;
        end else if (mag > cfg_limit) begin
          val = cfg_limit;
          st  = StatusRange;
        end
      end
    end
    res.value  = val;
    res.status = st;

    acc_val       = '0;
    acc_ovf       = 1'b0;
    neg_seen      = 1'b0;
    first_pending = 1'b1;
    literal_next  = 1'b0;
    any_digit     = 1'b0;
    bad_seen      = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned dv);
    if (dv < 10) return 8'h30 + 8'(dv);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(dv - 10);
  endfunction

  task automatic queue_byte(input logic [7:0] c, input bit last, input bit typed,
                            input out_beat_t known);
    pending_beat_t pb;
    pb.beat.char_byte = c;
    pb.beat.is_last   = last;
    pb.typed          = typed;
    pb.known          = known;
    byte_queue.push_back(pb);
    beats_sent++;
    if (last) strings_sent++;
  endtask

  // Well-formed number with random content, now and then broken.
  task automatic queue_number_string();
    logic [63:0]  target;
    logic [7:0]   digs[$];
    int unsigned  pick;
    int unsigned  r;
    int unsigned  k;
    int unsigned  nzero;
    r = (cfg_radix >= 6'd2 && cfg_radix <= RadixMax) ? int'(cfg_radix) : 10;
    pick = $urandom_range(0, 99);
    if (pick < 40) target = 64'($urandom_range(0, 2000));
    else if (pick < 60) target = {$urandom, $urandom} >> $urandom_range(0, 63);
    else if (pick < 80) target = cfg_limit + 64'($urandom_range(0, 4)) - 64'd2;
    else target = ValueMax - 64'($urandom_range(0, 2));
    do begin
      digs.push_front(digit_char(int'(target % 64'(r))));
      target = target / 64'(r);
    end while (target != 0);
    if (pick >= 80 && $urandom_range(0, 1)) digs.push_back(digit_char($urandom_range(0, r - 1)));
    nzero = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
    for (k = 0; k < nzero; k++) digs.push_front(8'h30);
    if ($urandom_range(0, 99) < 8) digs[$urandom_range(0, digs.size() - 1)] = 8'($urandom);
    if ($urandom_range(0, 9) < 3) queue_byte(CharMinus, 1'b0, 1'b0, '0);
    for (k = 0; k < digs.size(); k++) begin
      if (k > 0 && $urandom_range(0, 9) == 0) queue_byte(CharUnder, 1'b0, 1'b0, '0);
      queue_byte(digs[k], k == digs.size() - 1, 1'b0, '0);
    end
  endtask

  task automatic queue_noise_string();
    int unsigned len;
    int unsigned k;
    logic [7:0]  c;
    len = $urandom_range(1, 5);
    for (k = 0; k < len; k++) begin
      case ($urandom_range(0, 4))
        0, 1:    c = 8'($urandom);
        2:       c = CharUnder;
        3:       c = CharMinus;
        default: c = digit_char($urandom_range(0, 35));
      endcase
      queue_byte(c, k == len - 1, 1'b0, '0);
    end
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk); while (!cfg_ready_o);
  endtask

  task automatic drain();
    while (byte_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sender: bursts of beats with random gaps
  always @(negedge clk) begin
    if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= byte_queue[0].beat;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (steady_send) gap_left = 0;
          else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(4, 12);
          else gap_left = $urandom_range(0, 3);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LongHold;
      out_ready_i <= 1'b0;
    end else if (steady_recv) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= recv_pattern[pat_idx];
      pat_idx = pat_idx + 4'd1;
    end
  end

  always @(posedge clk) begin
    pending_beat_t pb;
    out_beat_t     res;
    out_beat_t     want;
    bit            fired;
    if (rst_ni) begin
      fired = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        fired = 1'b1;
        case (cfg_index_i)
          RegRadix:  cfg_radix = cfg_data_i[RadixW-1:0];
          RegLimit:  cfg_limit = cfg_data_i;
          RegNegate: cfg_neg   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        fired    = 1'b1;
        in_taken = 1'b1;
        pb = byte_queue.pop_front();
        if (scan_byte(pb.beat, res)) expected_results.push_back(pb.typed ? pb.known : res);
      end
      if (out_valid_o && out_ready_i) begin
        fired = 1'b1;
        if (expected_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result beat: value %h status %0d",
                     out_data_o.value, out_data_o.status);
          end
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.status == StatusInvalid) invalid_seen++;
          if (want.status == StatusRange) range_seen++;
          if (out_data_o.value !== want.value || out_data_o.status !== want.status) begin
            if (mismatches < 10) begin
              $display("result mismatch: value %h status %0d, expected value %h status %0d",
                       out_data_o.value, out_data_o.status, want.value, want.status);
            end
            mismatches++;
          end
        end
      end
      if (fired) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no beat moved for %0d cycles", WatchdogLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned       phase;
    int unsigned       budget_end;
    logic [RadixW-1:0] r;
    logic [ValueW-1:0] lim;
    bit                ng;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      queue_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].known);
    end
    drain();

    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:  begin r = 6'd10; lim = ValueMax;                 ng = 1'b0; end
        1:  begin r = 6'd2;  lim = ValueMax;                 ng = 1'b1; end
        2:  begin r = 6'd36; lim = 64'h8000_0000_0000_0000;  ng = 1'b0; end
        3:  begin r = 6'd16; lim = 64'h7fff_ffff_ffff_ffff;  ng = 1'b0; end
        4:  begin r = 6'd10; lim = 64'h8000_0000_0000_0000;  ng = 1'b1; end
        5:  begin r = 6'd8;  lim = 64'd0;                    ng = 1'b0; end
        6:  begin r = 6'd36; lim = 64'd1;                    ng = 1'b1; end
        7:  begin r = 6'd0;  lim = ValueMax;                 ng = 1'b0; end
        8:  begin r = 6'd1;  lim = 64'd1000;                 ng = 1'b1; end
        9:  begin r = 6'd37; lim = 64'd2;                    ng = 1'b0; end
        10: begin r = 6'd63; lim = ValueMax - 64'd1;         ng = 1'b0; end
        11: begin r = 6'd3;  lim = 64'd1000;                 ng = 1'b0; end
        12: begin r = 6'd35; lim = 64'd999;                  ng = 1'b1; end
        default: begin
          r   = 6'($urandom_range(2, 36));
          lim = {$urandom, $urandom} >> $urandom_range(0, 63);
          ng  = 1'($urandom_range(0, 1));
        end
      endcase
      write_register(RegRadix, {58'd0, r});
      write_register(RegLimit, lim);
      write_register(RegNegate, {63'd0, ng});
      @(negedge clk);
      cfg_valid_i <= 1'b0;

      steady_send  = (phase % 4 == 0) || (phase == HoldPhase);
      steady_recv  = (phase % 5 == 2) && (phase != HoldPhase);
      recv_pattern = 16'($urandom) | 16'h0001;
      if (phase == HoldPhase) hold_req = 1'b1;

      budget_end = beats_sent + PhaseBeats;
      while (beats_sent < budget_end) begin
        if ($urandom_range(0, 99) < 75) queue_number_string();
        else queue_noise_string();
      end
      drain();
    end

    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    $display("Scanned %0d bytes in %0d strings: hand-picked table, then %0d register settings.",
             beats_sent, strings_sent, NumPhases);
    $display("Checked %0d results (%0d invalid, %0d out of range), %0d mismatches.",
             results_checked, invalid_seen, range_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/iss_pkg.sv
rtl/core/iss_step.sv
rtl/core/iss_finish.sv
rtl/core/integer_string_scanner.sv
sim/integer_string_scanner_test.sv
